// ===== src/epba_pkg.sv =====
`timescale 1ns / 1ps
package epba_pkg;

  // edge kinds
  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_DMU = 2'd1;
  localparam logic [1:0] KIND_DTH = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // phase constants, Q4.28
  localparam logic signed [32:0] PH_PI      = 33'sd843314857;
  localparam logic signed [32:0] PH_TWO_PI  = 33'sd1686629713;
  localparam logic signed [32:0] PH_HALF_PI = 33'sd421657428;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  localparam int MAG_W = 62;
  localparam logic [63:0] MAG_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               flip;
  } cordic_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               m_neg;
    logic [MAG_W-1:0]   m_mag;
    logic signed [31:0] diag;
  } side_t;

endpackage

// ===== src/epba_front.sv =====
`timescale 1ns / 1ps
module epba_front #(
  parameter int NODE_BITS = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [1:0]                 kind,
  input  logic [NODE_BITS-1:0]       node_first,
  input  logic [NODE_BITS-1:0]       node_second,
  input  logic signed [31:0]         edge_coef,
  input  logic [31:0]                thick_first,
  input  logic [31:0]                thick_second,
  input  logic signed [31:0]         phase,
  input  logic signed [31:0]         phase_deriv,
  output logic                       vld,
  output epba_pkg::cordic_t          cst,
  output epba_pkg::side_t            side,
  output logic [2*NODE_BITS-1:0]     nodes
);
  import epba_pkg::*;

  localparam int AMW = 63 - FRAC_BITS;
  localparam int TW  = 95 - FRAC_BITS;
  localparam int TSW = TW - FRAC_BITS;
  localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);

  // stage 1
  logic v1;
  logic [1:0] k1;
  logic [2*NODE_BITS-1:0] n1;
  logic signed [31:0] coef1, da1, p1;
  logic [31:0] mean1;
  // stage 2
  logic v2, sa2, flip2;
  logic [1:0] k2;
  logic [2*NODE_BITS-1:0] n2;
  logic signed [31:0] da2, p2;
  logic [63:0] prod2;
  // stage 3
  logic v3, sa3, sd3, flip3;
  logic [1:0] k3;
  logic [2*NODE_BITS-1:0] n3;
  logic [AMW-1:0] amag3;
  logic [31:0] dmag3;
  logic signed [31:0] z3;
  // stage 4
  logic v4, sa4, st4, flip4;
  logic [1:0] k4;
  logic [2*NODE_BITS-1:0] n4;
  logic [AMW-1:0] amag4, pphi4;
  logic [63:0] pplo4;
  logic signed [31:0] z4;

  logic [32:0] tsum;
  logic signed [32:0] ph_ext, p1_ext;
  logic signed [31:0] p1_next, p2_next;
  logic flip_next;
  logic [31:0] coef_mag;
  logic [63:0] asum;
  logic [TW-1:0] tfull;
  logic [TSW-1:0] tsh;
  logic [MAG_W-1:0] tmag;
  logic signed [31:0] diag_next;

  always_comb begin
    tsum   = {1'b0, thick_first} + {1'b0, thick_second};
    ph_ext = 33'(phase);
    // fold into one turn
    if (ph_ext >= PH_PI) begin
      p1_next = 32'(ph_ext - PH_TWO_PI);
    end else if (ph_ext < -PH_PI) begin
      p1_next = 32'(ph_ext + PH_TWO_PI);
    end else begin
      p1_next = 32'(ph_ext);
    end
    // fold into the right half plane
    p1_ext = 33'(p1);
    flip_next = 1'b1;
    if (p1_ext > PH_HALF_PI) begin
      p2_next = 32'(p1_ext - PH_PI);
    end else if (p1_ext < -PH_HALF_PI) begin
      p2_next = 32'(p1_ext + PH_PI);
    end else begin
      p2_next   = p1;
      flip_next = 1'b0;
    end
    coef_mag = coef1[31] ? 32'(-coef1) : 32'(coef1);
    asum     = prod2 + RND;
    tfull = (TW'(pphi4) << 32) + TW'(pplo4) + TW'(RND);
    tsh   = TSW'(tfull >> FRAC_BITS);
    tmag  = (96'(tsh) > 96'(MAG_LIM)) ? MAG_W'(MAG_LIM) : MAG_W'(tsh);
    // diagonal is -alpha for regular edges, saturated; zero for other kinds
    if (k4 != KIND_REG) begin
      diag_next = '0;
    end else if (sa4) begin
      diag_next = (64'(amag4) > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(amag4);
    end else begin
      diag_next = (64'(amag4) >= 64'h8000_0000) ? 32'sh8000_0000 : 32'd0 - 32'(amag4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vld <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1    <= kind;
      n1    <= {node_second, node_first};
      coef1 <= edge_coef;
      da1   <= phase_deriv;
      mean1 <= tsum[32:1];
      p1    <= p1_next;

      k2    <= k1;
      n2    <= n1;
      da2   <= da1;
      prod2 <= 64'(coef_mag) * 64'(mean1);
      sa2   <= coef1[31];
      p2    <= p2_next;
      flip2 <= flip_next;

      k3    <= k2;
      n3    <= n2;
      sa3   <= sa2;
      amag3 <= AMW'(asum >> FRAC_BITS);
      dmag3 <= da2[31] ? 32'(-da2) : 32'(da2);
      sd3   <= da2[31];
      z3    <= $signed({p2[29:0], 2'b00});
      flip3 <= flip2;

      k4    <= k3;
      n4    <= n3;
      sa4   <= sa3;
      st4   <= sa3 ^ sd3;
      amag4 <= amag3;
      pplo4 <= 64'(amag3[31:0]) * 64'(dmag3);
      pphi4 <= AMW'(amag3[AMW-1:32]) * AMW'(dmag3);
      z4    <= z3;
      flip4 <= flip3;

      nodes      <= n4;
      side.kind  <= k4;
      side.m_neg <= (k4 == KIND_REG) ? sa4 : st4;
      side.m_mag <= (k4 == KIND_REG) ? MAG_W'(amag4) : tmag;
      side.diag  <= diag_next;
      cst.x      <= CORDIC_GAIN;
      cst.y      <= '0;
      cst.z      <= z4;
      cst.flip   <= flip4;
    end
  end

endmodule

// ===== src/epba_cell.sv =====
`timescale 1ns / 1ps
module epba_cell #(
  parameter int STEP = 0,
  parameter int NW = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  epba_pkg::cordic_t st_in,
  input  epba_pkg::side_t   side_in,
  input  logic [NW-1:0]     nodes_in,
  output logic              vld_out,
  output epba_pkg::cordic_t st_out,
  output epba_pkg::side_t   side_out,
  output logic [NW-1:0]     nodes_out
);
  import epba_pkg::*;

  logic signed [32:0] xs, ys;
  logic signed [31:0] ang;

  assign xs  = st_in.x >>> STEP;
  assign ys  = st_in.y >>> STEP;
  assign ang = $signed(ATAN_TAB[STEP]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // rotate toward zero residual angle
      if (st_in.z >= 0) begin
        st_out.x <= st_in.x - ys;
        st_out.y <= st_in.y + xs;
        st_out.z <= st_in.z - ang;
      end else begin
        st_out.x <= st_in.x + ys;
        st_out.y <= st_in.y - xs;
        st_out.z <= st_in.z + ang;
      end
      st_out.flip <= st_in.flip;
      side_out    <= side_in;
      nodes_out   <= nodes_in;
    end
  end

endmodule

// ===== src/epba_back.sv =====
`timescale 1ns / 1ps
module epba_back #(
  parameter int NODE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vld_in,
  input  epba_pkg::cordic_t      st_in,
  input  epba_pkg::side_t        side_in,
  input  logic [2*NODE_BITS-1:0] nodes_in,
  output logic                   out_valid,
  output logic signed [31:0]     cos_term,
  output logic signed [31:0]     sin_term,
  output logic signed [31:0]     diag_term,
  output logic [NODE_BITS:0]     row_first_re,
  output logic [NODE_BITS:0]     row_first_im,
  output logic [NODE_BITS:0]     row_second_re,
  output logic [NODE_BITS:0]     row_second_im,
  output logic                   bad_kind
);
  import epba_pkg::*;

  function automatic logic [31:0] round_sat(input logic [62:0] ph, input logic [62:0] pl,
                                            input logic neg);
    logic [94:0] full;
    logic [64:0] r;
    full = (95'(ph) << 31) + 95'(pl) + (95'd1 << 29);
    r = full[94:30];
    if (neg) begin
      round_sat = (r >= 65'h8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
    end else begin
      round_sat = (r > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  endfunction

  logic signed [32:0] cs, sn, opc, ops;
  // stage 1
  logic v1, cneg1, sneg1;
  logic [31:0] cmag1, smag1;
  side_t side1;
  logic [2*NODE_BITS-1:0] n1;
  // stage 2
  logic v2, cneg2, sneg2;
  logic [62:0] pch2, pcl2, psh2, psl2;
  side_t side2;
  logic [2*NODE_BITS-1:0] n2;

  always_comb begin
    cs = st_in.flip ? -st_in.x : st_in.x;
    sn = st_in.flip ? -st_in.y : st_in.y;
    if (side_in.kind == KIND_REG) begin
      opc = cs;
      ops = sn;
    end else begin
      opc = -sn;
      ops = cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= vld_in;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmag1 <= opc[32] ? 32'(-opc) : 32'(opc);
      smag1 <= ops[32] ? 32'(-ops) : 32'(ops);
      cneg1 <= side_in.m_neg ^ opc[32];
      sneg1 <= side_in.m_neg ^ ops[32];
      side1 <= side_in;
      n1    <= nodes_in;

      pcl2  <= 63'(side1.m_mag[30:0]) * 63'(cmag1);
      pch2  <= 63'(side1.m_mag[61:31]) * 63'(cmag1);
      psl2  <= 63'(side1.m_mag[30:0]) * 63'(smag1);
      psh2  <= 63'(side1.m_mag[61:31]) * 63'(smag1);
      cneg2 <= cneg1;
      sneg2 <= sneg1;
      side2 <= side1;
      n2    <= n1;

      if (side2.kind == KIND_BAD) begin
        cos_term  <= '0;
        sin_term  <= '0;
        diag_term <= '0;
        bad_kind  <= 1'b1;
      end else begin
        cos_term  <= round_sat(pch2, pcl2, cneg2);
        sin_term  <= round_sat(psh2, psl2, sneg2);
        diag_term <= side2.diag;
        bad_kind  <= 1'b0;
      end
      row_first_re  <= {n2[NODE_BITS-1:0], 1'b0};
      row_first_im  <= {n2[NODE_BITS-1:0], 1'b1};
      row_second_re <= {n2[2*NODE_BITS-1:NODE_BITS], 1'b0};
      row_second_im <= {n2[2*NODE_BITS-1:NODE_BITS], 1'b1};
    end
  end

endmodule

// ===== src/edge_phase_block_assembly.sv =====
`timescale 1ns / 1ps
// Edge block assembly: takes one mesh edge per request and returns its complex
// 2x2 block entries (cos_term, sin_term, diag_term, signed Q16.16 saturated)
// and the four real and imaginary row numbers of its two nodes. A new request
// is taken every cycle unless the pipeline holds; each request passes through 5
// front stages (thickness mean, phase fold, edge weight and derivative
// products), a chain of 30 CORDIC cells, one rotation per cell, and 3 back
// stages (operand select, split products, rounding and saturation). The whole
// pipeline advances together and holds only while a finished result waits on
// out_ready, so in_ready follows out_ready within the same cycle. No reset
// sweep and no configuration; rows are valid for illegal kinds too.
module edge_phase_block_assembly #(
  parameter int NODE_BITS = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [NODE_BITS-1:0]   node_first,
  input  logic [NODE_BITS-1:0]   node_second,
  input  logic signed [31:0]     edge_coef,
  input  logic [31:0]            thick_first,
  input  logic [31:0]            thick_second,
  input  logic signed [31:0]     phase,
  input  logic signed [31:0]     phase_deriv,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     cos_term,
  output logic signed [31:0]     sin_term,
  output logic signed [31:0]     diag_term,
  output logic [NODE_BITS:0]     row_first_re,
  output logic [NODE_BITS:0]     row_first_im,
  output logic [NODE_BITS:0]     row_second_re,
  output logic [NODE_BITS:0]     row_second_im,
  output logic                   bad_kind
);
  import epba_pkg::*;

  // whole pipe moves unless the output register is full and stalled
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                   vl  [CORDIC_STEPS+1];
  cordic_t                cst [CORDIC_STEPS+1];
  side_t                  sd  [CORDIC_STEPS+1];
  logic [2*NODE_BITS-1:0] nd  [CORDIC_STEPS+1];

  epba_front #(
    .NODE_BITS(NODE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .kind        (kind),
    .node_first  (node_first),
    .node_second (node_second),
    .edge_coef   (edge_coef),
    .thick_first (thick_first),
    .thick_second(thick_second),
    .phase       (phase),
    .phase_deriv (phase_deriv),
    .vld         (vl[0]),
    .cst         (cst[0]),
    .side        (sd[0]),
    .nodes       (nd[0])
  );

  // rotation chain, one CORDIC step per cell, payload rides along
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    epba_cell #(
      .STEP(i),
      .NW  (2 * NODE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (vl[i]),
      .st_in    (cst[i]),
      .side_in  (sd[i]),
      .nodes_in (nd[i]),
      .vld_out  (vl[i+1]),
      .st_out   (cst[i+1]),
      .side_out (sd[i+1]),
      .nodes_out(nd[i+1])
    );
  end

  epba_back #(
    .NODE_BITS(NODE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .vld_in       (vl[CORDIC_STEPS]),
    .st_in        (cst[CORDIC_STEPS]),
    .side_in      (sd[CORDIC_STEPS]),
    .nodes_in     (nd[CORDIC_STEPS]),
    .out_valid    (out_valid),
    .cos_term     (cos_term),
    .sin_term     (sin_term),
    .diag_term    (diag_term),
    .row_first_re (row_first_re),
    .row_first_im (row_first_im),
    .row_second_re(row_second_re),
    .row_second_im(row_second_im),
    .bad_kind     (bad_kind)
  );

endmodule

// ===== src/epba_checker.sv =====
`timescale 1ns / 1ps
module epba_checker #(
  parameter int NODE_BITS = 20
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [31:0]   cos_term,
  input logic signed [31:0]   sin_term,
  input logic signed [31:0]   diag_term,
  input logic [NODE_BITS:0]   row_first_re,
  input logic [NODE_BITS:0]   row_first_im,
  input logic [NODE_BITS:0]   row_second_re,
  input logic [NODE_BITS:0]   row_second_im,
  input logic                 bad_kind
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cos_term) && $stable(sin_term)
      && $stable(diag_term) && $stable(row_first_re) && $stable(bad_kind))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_kind |-> cos_term == 0 && sin_term == 0 && diag_term == 0)
    else $error("illegal kind gave nonzero entries");

  a_row_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_first_im == (row_first_re | 1) && !row_first_re[0]
      && row_second_im == (row_second_re | 1) && !row_second_re[0])
    else $error("row pair mismatch");

endmodule

bind edge_phase_block_assembly epba_checker #(
  .NODE_BITS(NODE_BITS)
) u_epba_checker (.*);

// ===== tb/edge_block_checker.sv =====
`timescale 1ns / 1ps
module edge_block_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [19:0]        node_first,
  input  logic [19:0]        node_second,
  input  logic signed [31:0] edge_coef,
  input  logic [31:0]        thick_first,
  input  logic [31:0]        thick_second,
  input  logic signed [31:0] phase,
  input  logic signed [31:0] phase_deriv,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] cos_term,
  input  logic signed [31:0] sin_term,
  input  logic signed [31:0] diag_term,
  input  logic [20:0]        row_first_re,
  input  logic [20:0]        row_first_im,
  input  logic [20:0]        row_second_re,
  input  logic [20:0]        row_second_im,
  input  logic               bad_kind,
  output int                 fail_count,
  output int                 pending
);
  import epba_pkg::*;

  localparam longint WIDE_CAP = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] d;
    logic [20:0]        r1re;
    logic [20:0]        r1im;
    logic [20:0]        r2re;
    logic [20:0]        r2im;
    logic               bad;
  } edge_block_t;

  edge_block_t block_queue[$];

  // exact product, rounded half away from zero, magnitude capped
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > 128'(WIDE_CAP)) p = 128'(WIDE_CAP);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic rotate_phase(input longint ph, output longint cs, output longint sn);
    longint p;
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    p = ph;
    flip = 0;
    x = longint'(CORDIC_GAIN);
    y = 0;
    if (p >= longint'(PH_PI)) p = p - longint'(PH_TWO_PI);
    else if (p < -longint'(PH_PI)) p = p + longint'(PH_TWO_PI);
    if (p > longint'(PH_HALF_PI)) begin
      p = p - longint'(PH_PI);
      flip = 1;
    end else if (p < -longint'(PH_HALF_PI)) begin
      p = p + longint'(PH_PI);
      flip = 1;
    end
    z = p * 4;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic predict_block(output edge_block_t e);
    longint mean;
    longint alpha;
    longint cs;
    longint sn;
    longint t;
    mean = longint'(({1'b0, thick_first} + {1'b0, thick_second}) >> 1);
    alpha = mul_round(longint'(edge_coef), mean, 16);
    rotate_phase(longint'(phase), cs, sn);
    e.c = '0;
    e.s = '0;
    e.d = '0;
    e.bad = 0;
    case (kind)
      KIND_REG: begin
        e.c = clip32(mul_round(alpha, cs, 30));
        e.s = clip32(mul_round(alpha, sn, 30));
        e.d = clip32(-alpha);
      end
      KIND_DMU, KIND_DTH: begin
        t = mul_round(alpha, longint'(phase_deriv), 16);
        e.c = clip32(mul_round(t, -sn, 30));
        e.s = clip32(mul_round(t, cs, 30));
      end
      default: e.bad = 1;
    endcase
    e.r1re = {node_first, 1'b0};
    e.r1im = {node_first, 1'b1};
    e.r2re = {node_second, 1'b0};
    e.r2im = {node_second, 1'b1};
  endtask

  initial fail_count = 0;
  assign pending = block_queue.size();

  always @(posedge clk) begin
    edge_block_t e;
    edge_block_t w;
    if (!rst && in_valid && in_ready) begin
      predict_block(e);
      block_queue.push_back(e);
    end
    if (!rst && out_valid && out_ready) begin
      if (block_queue.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        w = block_queue.pop_front();
        if (cos_term !== w.c) begin
          $error("cos_term expected %0d got %0d", w.c, cos_term);
          fail_count++;
        end
        if (sin_term !== w.s) begin
          $error("sin_term expected %0d got %0d", w.s, sin_term);
          fail_count++;
        end
        if (diag_term !== w.d) begin
          $error("diag_term expected %0d got %0d", w.d, diag_term);
          fail_count++;
        end
        if (row_first_re !== w.r1re) begin
          $error("row_first_re expected %0d got %0d", w.r1re, row_first_re);
          fail_count++;
        end
        if (row_first_im !== w.r1im) begin
          $error("row_first_im expected %0d got %0d", w.r1im, row_first_im);
          fail_count++;
        end
        if (row_second_re !== w.r2re) begin
          $error("row_second_re expected %0d got %0d", w.r2re, row_second_re);
          fail_count++;
        end
        if (row_second_im !== w.r2im) begin
          $error("row_second_im expected %0d got %0d", w.r2im, row_second_im);
          fail_count++;
        end
        if (bad_kind !== w.bad) begin
          $error("bad_kind expected %0d got %0d", w.bad, bad_kind);
          fail_count++;
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import epba_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         kind = KIND_REG;
  logic [19:0]        node_first = '0;
  logic [19:0]        node_second = '0;
  logic signed [31:0] edge_coef = '0;
  logic [31:0]        thick_first = '0;
  logic [31:0]        thick_second = '0;
  logic signed [31:0] phase = '0;
  logic signed [31:0] phase_deriv = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] cos_term;
  logic signed [31:0] sin_term;
  logic signed [31:0] diag_term;
  logic [20:0]        row_first_re;
  logic [20:0]        row_first_im;
  logic [20:0]        row_second_re;
  logic [20:0]        row_second_im;
  logic               bad_kind;
  int                 fail_count;
  int                 pending;

  // idle percentages for the current phase of the run
  int  send_idle = 32;
  int  recv_idle = 79;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  edge_phase_block_assembly uut (.*);
  edge_block_checker chk (.*);

  always #5 clk = ~clk;

  // receiver: random stalls, plus one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 300;
      hold_req <= 0;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // offer one request, hold it until taken, then maybe idle a few cycles
  task automatic send_edge(input logic [1:0] k, input logic [19:0] n1, input logic [19:0] n2,
                           input logic [31:0] cf, input logic [31:0] t1,
                           input logic [31:0] t2, input logic [31:0] ph,
                           input logic [31:0] dp);
    kind <= k;
    node_first <= n1;
    node_second <= n2;
    edge_coef <= cf;
    thick_first <= t1;
    thick_second <= t2;
    phase <= ph;
    phase_deriv <= dp;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // half plain random, otherwise an extreme or a small magnitude
  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'(int'($urandom_range(262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  // phase values near the fold boundaries matter most
  function automatic logic [31:0] pick_phase();
    case ($urandom_range(5))
      0: return 32'(843314857 + int'($urandom_range(4)) - 2);
      1: return 32'(-843314857 + int'($urandom_range(4)) - 2);
      2: return 32'(421657428 + int'($urandom_range(4)) - 2);
      3: return 32'(-421657428 + int'($urandom_range(4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_edges(input int count);
    logic [31:0] cf;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < count; i++) begin
      cf = pick32();
      t1 = ($urandom_range(3) == 0) ? pick32() : $urandom_range(1 << 20);
      t2 = ($urandom_range(3) == 0) ? pick32() : $urandom_range(1 << 20);
      send_edge(2'($urandom_range(3)), 20'($urandom), 20'($urandom), cf, t1, t2,
                pick_phase(), pick32());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every kind, field extremes, phase fold boundaries
    send_edge(KIND_REG, 20'd0, 20'hFFFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'd0, 32'd0);
    send_edge(KIND_DMU, 20'hFFFFF, 20'd0, 32'h0001_0000, 32'h0002_0000, 32'd0,
              32'd421657428, 32'h0001_0000);
    send_edge(KIND_DTH, 20'h5A5A5, 20'hA5A5A, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000,
              -32'sd421657428, 32'hFFFF_0000);
    send_edge(KIND_BAD, 20'hFFFFF, 20'hFFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_edge(KIND_REG, 20'h12345, 20'h54321, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h8000_0000);
    send_edge(KIND_REG, 20'd1, 20'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'd0);
    send_edge(KIND_DMU, 20'd3, 20'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd843314857, 32'h7FFF_FFFF);
    send_edge(KIND_DTH, 20'd5, 20'd6, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              -32'sd843314857, 32'h8000_0000);
    send_edge(KIND_REG, 20'd7, 20'd8, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'd843314856, 32'h1234_5678);
    send_edge(KIND_REG, 20'd9, 20'd10, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              -32'sd843314858, 32'd0);
    send_edge(KIND_REG, 20'd11, 20'd12, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'd421657429, 32'd0);
    send_edge(KIND_REG, 20'd13, 20'd14, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              -32'sd421657429, 32'd0);
    send_edge(KIND_DMU, 20'd15, 20'd16, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1);
    send_edge(KIND_DTH, 20'd17, 20'd18, 32'hFFFF_FFFF, 32'd1, 32'd2, -32'sd1, 32'hFFFF_FFFF);
    send_edge(KIND_BAD, 20'd0, 20'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_edge(KIND_REG, 20'hAAAAA, 20'h55555, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd12345, 32'd0);

    random_edges(500);

    // swap the idling sides
    send_idle = 79;
    recv_idle = 32;
    random_edges(500);

    // no idling; one long receiver hold-off fills the pipe
    send_idle = 0;
    recv_idle = 0;
    hold_req <= 1;
    random_edges(500);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
